// ----- src/escape_sequence_to_utf16_decoder_top_macros.svh -----
// Assertion macros for the escape sequence decoder.
// Included by the top level; no other dependencies.
`ifndef ESCAPE_SEQUENCE_TO_UTF16_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_TO_UTF16_DECODER_TOP_MACROS_SVH

// Implication within the same cycle
`define ESUD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esud assertion failed");

// Implication checked in the next cycle
`define ESUD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esud assertion failed");

`endif

// ----- src/esud_pkg.sv -----
// Shared types and constants of the escape sequence to UTF-16 decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package esud_pkg;

   // Default depth of the result queue (at least 3 for full rate)
   localparam int ESUD_OUTQ_DEPTH = 4;

   // Character codes
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_N         = 16'h006E;
   localparam logic [15:0] CH_B         = 16'h0062;
   localparam logic [15:0] CH_R         = 16'h0072;
   localparam logic [15:0] CH_T         = 16'h0074;
   localparam logic [15:0] CH_X         = 16'h0078;
   localparam logic [15:0] CH_U_LOW     = 16'h0075;
   localparam logic [15:0] CH_U_UP      = 16'h0055;
   localparam logic [15:0] UNIT_LF      = 16'h000A;
   localparam logic [15:0] UNIT_BS      = 16'h0008;
   localparam logic [15:0] UNIT_CR      = 16'h000D;
   localparam logic [15:0] UNIT_TAB     = 16'h0009;

   // Hex digit ranges, either case
   localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
   localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
   localparam logic [15:0] CH_HEX_A_UP  = 16'h0041;
   localparam logic [15:0] CH_HEX_F_UP  = 16'h0046;
   localparam logic [15:0] CH_HEX_A_LO  = 16'h0061;
   localparam logic [15:0] CH_HEX_F_LO  = 16'h0066;

   // Code point limits and surrogate bases
   localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
   localparam logic [15:0] CP_REPLACE   = 16'hFFFD;
   localparam logic [20:0] CP_SUPP_BASE = 21'h01_0000;
   localparam logic [5:0]  SURR_HIGH    = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  SURR_LOW     = 6'b110111;  // 0xDC00 >> 10

   // Hex digit counts for \x, \u and \U
   localparam logic [3:0]  DIGITS_X     = 4'd2;
   localparam logic [3:0]  DIGITS_U4    = 4'd4;
   localparam logic [3:0]  DIGITS_U8    = 4'd8;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'b001,
      MODE_ESCAPED = 3'b010,
      MODE_HEX     = 3'b100
   } mode_type;

   // One result transaction
   typedef struct packed {
      logic [15:0] unit_out;
      logic        unit_valid;
      logic        last_of_run;
      logic        end_of_text;
   } res_type;

   // Results caused by one input character (0, 1 or 2 of them)
   typedef struct packed {
      res_type     first;
      res_type     second;
      logic [1:0]  num;
   } res_pair_type;

endpackage

// ----- src/esud_decode.sv -----
// Escape decoder: mode/code state registers and the per-character decode.
// Depends on esud_pkg.
`timescale 1ns / 1ps

module esud_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [15:0]           char_in,
   input  logic                  is_last,
   output esud_pkg::res_pair_type pair
);
   import esud_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [31:0] code_accum_ff, code_accum_in;
   logic [3:0]  digits_left_ff, digits_left_in;

   logic        do_unit;
   logic [15:0] unit_val;
   logic        do_code;
   logic [31:0] code_val;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_sat;
   logic        cp_wide;
   logic [20:0] cp_sub;
   logic [15:0] surr_hi;
   logic [15:0] surr_lo;

   // Hex digit recognition, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (char_in >= CH_DIGIT_0 && char_in <= CH_DIGIT_9) begin
         hex_val = 4'(char_in - CH_DIGIT_0);
      end else if (char_in >= CH_HEX_A_UP && char_in <= CH_HEX_F_UP) begin
         hex_val = 4'(char_in - CH_HEX_A_UP + 16'd10);
      end else if (char_in >= CH_HEX_A_LO && char_in <= CH_HEX_F_LO) begin
         hex_val = 4'(char_in - CH_HEX_A_LO + 16'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Next state and the single unit or code this character yields
   always_comb begin
      mode_in        = mode_ff;
      code_accum_in  = code_accum_ff;
      digits_left_in = digits_left_ff;
      do_unit        = 1'b0;
      unit_val       = char_in;
      do_code        = 1'b0;
      case (mode_ff)
         MODE_ESCAPED: begin
            mode_in = MODE_NORMAL;
            if (char_in == CH_N) begin
               do_unit  = 1'b1;
               unit_val = UNIT_LF;
            end else if (char_in == CH_B) begin
               do_unit  = 1'b1;
               unit_val = UNIT_BS;
            end else if (char_in == CH_R) begin
               do_unit  = 1'b1;
               unit_val = UNIT_CR;
            end else if (char_in == CH_T) begin
               do_unit  = 1'b1;
               unit_val = UNIT_TAB;
            end else if (char_in == CH_X) begin
               code_accum_in  = '0;
               digits_left_in = DIGITS_X;
               mode_in        = MODE_HEX;
            end else if (char_in == CH_U_LOW) begin
               code_accum_in  = '0;
               digits_left_in = DIGITS_U4;
               mode_in        = MODE_HEX;
            end else if (char_in == CH_U_UP) begin
               code_accum_in  = '0;
               digits_left_in = DIGITS_U8;
               mode_in        = MODE_HEX;
            end else begin
               do_unit = 1'b1;
            end
         end
         MODE_HEX: begin
            if (hex_ok && digits_left_ff != 4'd0) begin
               code_accum_in  = {code_accum_ff[27:0], hex_val};
               digits_left_in = digits_left_ff - 4'd1;
            end else begin
               digits_left_in = 4'd0;
            end
            if (digits_left_in == 4'd0) begin
               do_code = 1'b1;
               mode_in = MODE_NORMAL;
            end
         end
         default: begin
            if (char_in == CH_BACKSLASH) begin
               mode_in = MODE_ESCAPED;
            end else begin
               do_unit = 1'b1;
            end
         end
      endcase
      // flush a code still being collected at end of text
      if (is_last && mode_in == MODE_HEX) begin
         do_code = 1'b1;
      end
      code_val = code_accum_in;
   end

   // Code point to one unit or a surrogate pair
   always_comb begin
      cp_wide = 1'b0;
      cp_sat  = code_val[15:0];
      if (code_val > CP_MAX) begin
         cp_sat = CP_REPLACE;
      end else if (code_val[31:16] != 16'd0) begin
         cp_wide = 1'b1;
      end
      cp_sub  = code_val[20:0] - CP_SUPP_BASE;
      surr_hi = {SURR_HIGH, cp_sub[19:10]};
      surr_lo = {SURR_LOW, cp_sub[9:0]};
   end

   // Assemble the result transactions
   always_comb begin
      pair.first  = '0;
      pair.second = '0;
      pair.num    = 2'd0;
      if (do_unit) begin
         pair.num               = 2'd1;
         pair.first.unit_out    = unit_val;
         pair.first.unit_valid  = 1'b1;
         pair.first.last_of_run = 1'b1;
         pair.first.end_of_text = is_last;
      end else if (do_code && !cp_wide) begin
         pair.num               = 2'd1;
         pair.first.unit_out    = cp_sat;
         pair.first.unit_valid  = 1'b1;
         pair.first.last_of_run = 1'b1;
         pair.first.end_of_text = is_last;
      end else if (do_code) begin
         pair.num                = 2'd2;
         pair.first.unit_out     = surr_hi;
         pair.first.unit_valid   = 1'b1;
         pair.second.unit_out    = surr_lo;
         pair.second.unit_valid  = 1'b1;
         pair.second.last_of_run = 1'b1;
         pair.second.end_of_text = is_last;
      end else if (is_last) begin
         // empty end marker
         pair.num               = 2'd1;
         pair.first.last_of_run = 1'b1;
         pair.first.end_of_text = 1'b1;
      end
   end

   // State registers; end of text returns to the reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         code_accum_ff  <= '0;
         digits_left_ff <= '0;
      end else if (take) begin
         if (is_last) begin
            mode_ff        <= MODE_NORMAL;
            code_accum_ff  <= '0;
            digits_left_ff <= '0;
         end else begin
            mode_ff        <= mode_in;
            code_accum_ff  <= code_accum_in;
            digits_left_ff <= digits_left_in;
         end
      end
   end

endmodule

// ----- src/esud_outq.sv -----
// Result queue: takes up to two result transactions per cycle, gives one while not stalled.
// Depends on esud_pkg.
`timescale 1ns / 1ps

module esud_outq #(
   parameter int DEPTH = esud_pkg::ESUD_OUTQ_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  esud_pkg::res_pair_type pair,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output esud_pkg::res_type      rsp_res
);
   import esud_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

   res_type          q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       num_push;
   logic             pop;

   always_comb begin
      num_push  = push ? pair.num : 2'd0;
      pop       = rsp_valid && !rsp_stall;
      wr_next   = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff;
      case (num_push)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = (wr_next == LAST_IDX) ? '0 : wr_next + 1'b1;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(num_push) - CNT_W'(pop);
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (num_push != 2'd0) begin
         q_ff[wr_ptr_ff] <= pair.first;
      end
      if (num_push == 2'd2) begin
         q_ff[wr_next] <= pair.second;
      end
   end

   // Room for a worst-case surrogate pair
   assign room      = (count_ff <= ROOM_MAX);
   assign rsp_valid = (count_ff != '0);
   assign rsp_res   = q_ff[rd_ptr_ff];

endmodule

// ----- src/escape_sequence_to_utf16_decoder_top.sv -----
// Escape sequence decoder, backslash escapes in, UTF-16 units out: the block
// accepts one character per cycle unless stalled; a character is registered in
// the input stage, decoded from there and written to a small result queue, which
// shows its first result on the rsp port. The single result port sets the rate at
// one result per cycle unless the receiver stalls, so the units of a surrogate
// pair leave in turn; the input stalls while a character waits in the stage and
// the queue has fewer than two free entries (OUTQ_DEPTH, at least 3).
// Depends on esud_pkg, esud_decode, esud_outq and the assertion macro header.
`timescale 1ns / 1ps
`include "escape_sequence_to_utf16_decoder_top_macros.svh"

module escape_sequence_to_utf16_decoder_top #(
   parameter int OUTQ_DEPTH = esud_pkg::ESUD_OUTQ_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_char_in,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_unit_out,
   output logic        rsp_unit_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_text
);
   import esud_pkg::*;

   logic         stage_valid_ff, stage_valid_in;
   logic [15:0]  stage_char_ff;
   logic         stage_last_ff;
   logic         room;
   logic         advance;
   logic         accept;
   res_pair_type pair;
   res_type      rsp_res;

   // Input stage handshake
   assign advance   = stage_valid_ff && room;
   assign req_stall = stage_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Input transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_char_ff <= req_char_in;
         stage_last_ff <= req_is_last;
      end
   end

   esud_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .take    (advance),
      .char_in (stage_char_ff),
      .is_last (stage_last_ff),
      .pair    (pair)
   );

   esud_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .pair      (pair),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_unit_out    = rsp_res.unit_out;
   assign rsp_unit_valid  = rsp_res.unit_valid;
   assign rsp_last_of_run = rsp_res.last_of_run;
   assign rsp_end_of_text = rsp_res.end_of_text;

   // Checks
   `ESUD_ASSERT_SAME(a_stall_only_when_held, clock, reset, req_stall, stage_valid_ff)
   `ESUD_ASSERT_SAME(a_marker_shape, clock, reset, rsp_valid && !rsp_unit_valid,
      rsp_end_of_text && rsp_last_of_run && rsp_unit_out == 16'd0)
   `ESUD_ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !room,
      stage_valid_ff && $stable(stage_char_ff) && $stable(stage_last_ff))

endmodule

// ----- tb/esud_result_checker.sv -----
// Result checker for the escape sequence to UTF-16 decoder: watches both channels,
// predicts the UTF-16 units of every accepted character and compares them in order.
// Depends on esud_pkg for the character codes, mode encoding and result layout.
`timescale 1ns / 1ps

module esud_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_char_in,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_unit_out,
   input  logic        rsp_unit_valid,
   input  logic        rsp_last_of_run,
   input  logic        rsp_end_of_text,
   output int          failure_count,
   output int          awaited_count
);
   import esud_pkg::*;

   localparam logic [4:0]  HEX_NONE    = 5'd16;
   localparam int          REPORT_MAX  = 10;

   // decoder state mirrored here
   mode_type    dec_mode;
   logic [31:0] code_sum;
   logic [3:0]  digits_due;

   // units produced by the character being decoded
   logic [15:0] run_units[$];
   // results still to come out of the block, oldest first
   res_type     pending_units[$];

   // digit value 0..15, HEX_NONE for anything else
   function automatic logic [4:0] hex_nibble(input logic [15:0] ch);
      if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
         return {1'b0, 4'(ch - CH_DIGIT_0)};
      if (ch >= CH_HEX_A_UP && ch <= CH_HEX_F_UP)
         return {1'b0, 4'(ch - CH_HEX_A_UP + 16'd10)};
      if (ch >= CH_HEX_A_LO && ch <= CH_HEX_F_LO)
         return {1'b0, 4'(ch - CH_HEX_A_LO + 16'd10)};
      return HEX_NONE;
   endfunction

   task automatic clear_decoder();
      dec_mode   = MODE_NORMAL;
      code_sum   = '0;
      digits_due = '0;
   endtask

   task automatic open_hex(input logic [3:0] digits);
      code_sum   = '0;
      digits_due = digits;
      dec_mode   = MODE_HEX;
   endtask

   // out-of-range codes are replaced, supplementary ones split into a pair
   task automatic emit_code_point(input logic [31:0] cp);
      logic [19:0] offset;
      if (cp > CP_MAX) begin
         run_units.push_back(CP_REPLACE);
      end else if (cp[31:16] == 16'h0000) begin
         run_units.push_back(cp[15:0]);
      end else begin
         offset = 20'(cp[20:0] - CP_SUPP_BASE);
         run_units.push_back({SURR_HIGH, offset[19:10]});
         run_units.push_back({SURR_LOW, offset[9:0]});
      end
   endtask

   // one accepted character: advance the state, queue the results it causes
   task automatic decode_char(input logic [15:0] ch, input logic last);
      logic [4:0] nib;
      res_type    item;
      int         k;
      run_units = {};
      nib = hex_nibble(ch);
      case (dec_mode)
         MODE_ESCAPED: begin
            dec_mode = MODE_NORMAL;
            case (ch)
               CH_N:     run_units.push_back(UNIT_LF);
               CH_B:     run_units.push_back(UNIT_BS);
               CH_R:     run_units.push_back(UNIT_CR);
               CH_T:     run_units.push_back(UNIT_TAB);
               CH_X:     open_hex(DIGITS_X);
               CH_U_LOW: open_hex(DIGITS_U4);
               CH_U_UP:  open_hex(DIGITS_U8);
               default:  run_units.push_back(ch);
            endcase
         end
         MODE_HEX: begin
            // a non-hex character closes the code and is dropped
            if (nib != HEX_NONE && digits_due != 4'd0) begin
               code_sum   = {code_sum[27:0], nib[3:0]};
               digits_due = digits_due - 4'd1;
            end else begin
               digits_due = 4'd0;
            end
            if (digits_due == 4'd0) begin
               emit_code_point(code_sum);
               dec_mode = MODE_NORMAL;
            end
         end
         default: begin
            if (ch == CH_BACKSLASH)
               dec_mode = MODE_ESCAPED;
            else
               run_units.push_back(ch);
         end
      endcase

      // end of text flushes a pending code; an open escape is dropped
      if (last && dec_mode == MODE_HEX)
         emit_code_point(code_sum);

      if (last && run_units.size() == 0) begin
         item.unit_out    = 16'h0000;
         item.unit_valid  = 1'b0;
         item.last_of_run = 1'b1;
         item.end_of_text = 1'b1;
         pending_units.push_back(item);
      end
      for (k = 0; k < run_units.size(); k++) begin
         item.unit_out    = run_units[k];
         item.unit_valid  = 1'b1;
         item.last_of_run = (k == run_units.size() - 1);
         item.end_of_text = (k == run_units.size() - 1) && last;
         pending_units.push_back(item);
      end

      if (last)
         clear_decoder();
   endtask

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_MAX)
         $display("%0t ns: %s", $realtime, msg);
   endtask

   task automatic check_result();
      res_type want;
      if (pending_units.size() == 0) begin
         note_failure($sformatf("unexpected result: unit %h valid %b run_end %b text_end %b",
                                rsp_unit_out, rsp_unit_valid, rsp_last_of_run,
                                rsp_end_of_text));
      end else begin
         want = pending_units.pop_front();
         if (want.unit_out !== rsp_unit_out || want.unit_valid !== rsp_unit_valid ||
             want.last_of_run !== rsp_last_of_run ||
             want.end_of_text !== rsp_end_of_text)
            note_failure($sformatf({"result mismatch: expected unit %h valid %b run_end %b",
                                    " text_end %b, got unit %h valid %b run_end %b",
                                    " text_end %b"},
                                   want.unit_out, want.unit_valid, want.last_of_run,
                                   want.end_of_text, rsp_unit_out, rsp_unit_valid,
                                   rsp_last_of_run, rsp_end_of_text));
      end
   endtask

   // sample both channels at the edge; results are checked before new input is decoded
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         pending_units = {};
         failure_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            decode_char(req_char_in, req_is_last);
      end
      awaited_count = pending_units.size();
   end

endmodule

// ----- tb/escape_sequence_to_utf16_decoder_top_tb.sv -----
// Top of the escape sequence decoder testbench: clock, reset, character stimulus
// and receiver stalls; checking is done by esud_result_checker.
// Depends on esud_pkg, esud_result_checker and escape_sequence_to_utf16_decoder_top.
`timescale 1ns / 1ps

module escape_sequence_to_utf16_decoder_top_tb;
   import esud_pkg::*;

   localparam int          RANDOM_ITEMS = 1100;
   localparam int          PRESSURE_AT  = 300;
   localparam int          PRESSURE_LEN = 120;
   localparam int          STILL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [15:0] ch;
      logic        last;
   } text_item_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [15:0]   req_char_in = 16'h0000;
   logic          req_is_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [15:0]   rsp_unit_out;
   logic          rsp_unit_valid;
   logic          rsp_last_of_run;
   logic          rsp_end_of_text;

   int            failure_count;
   int            awaited_count;
   int            still_cycles = 0;
   int            items_sent = 0;
   bit            quiet_tail = 1'b0;
   bit            pressure_done = 1'b0;
   text_item_type text_plan[$];

   escape_sequence_to_utf16_decoder_top uut (.*);

   esud_result_checker decode_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         still_cycles <= 0;
      end else begin
         still_cycles <= still_cycles + 1;
         if (still_cycles >= STILL_LIMIT) begin
            $display("escape_sequence_to_utf16_decoder_top regression: fail");
            $finish;
         end
      end
   end

   task automatic add_char(input logic [15:0] ch, input logic last);
      text_item_type item;
      item.ch   = ch;
      item.last = last;
      text_plan.push_back(item);
   endtask

   // receiver: random stall bursts, one long hold-off to back up the block
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (!quiet_tail && !pressure_done && items_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_LEN) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : req_side
      string       digits;
      int          d;
      int          p;
      int          pieces;
      int          pick;
      int          width;
      int          count;
      int          quiet_start;
      int          target;
      logic [31:0] code;
      logic [3:0]  nib;
      logic [15:0] ch;

      // directed: plain extremes, every simple escape, escaped other character
      add_char(16'h0000, 1'b0);
      add_char(16'hFFFF, 1'b0);
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_N, 1'b0);
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_B, 1'b0);
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_R, 1'b0);
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_T, 1'b0);
      add_char(CH_BACKSLASH, 1'b0); add_char(16'hFFFF, 1'b0);
      // \x cut short by a non-hex character
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_X, 1'b0); add_char(16'h0067, 1'b0);
      // \U at the top code point, mixed case: surrogate pair ending the text
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_U_UP, 1'b0);
      digits = "0010fFFf";
      for (d = 0; d < 8; d++)
         add_char({8'h00, digits[d]}, d == 7);
      // text ends while \u is collecting
      add_char(CH_BACKSLASH, 1'b0); add_char(CH_U_LOW, 1'b0); add_char(16'h0041, 1'b1);
      // text of a lone backslash: only the empty end marker
      add_char(CH_BACKSLASH, 1'b1);

      // random texts, mostly well-formed escapes with random content
      target = text_plan.size() + RANDOM_ITEMS;
      while (text_plan.size() < target) begin
         pieces = $urandom_range(1, 8);
         for (p = 0; p < pieces; p++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 1) begin
               if ($urandom_range(0, 2) == 0)
                  ch = 16'($urandom_range(0, 16'hFFFF));
               else
                  ch = 16'($urandom_range(16'h0020, 16'h007E));
               add_char(ch, 1'b0);
            end else if (pick == 2) begin
               add_char(CH_BACKSLASH, 1'b0);
               case ($urandom_range(0, 3))
                  0: add_char(CH_N, 1'b0);
                  1: add_char(CH_B, 1'b0);
                  2: add_char(CH_R, 1'b0);
                  default: add_char(CH_T, 1'b0);
               endcase
            end else if (pick == 3) begin
               add_char(CH_BACKSLASH, 1'b0);
               add_char(16'($urandom_range(0, 16'hFFFF)), 1'b0);
            end else begin
               // hex escape, sometimes short and closed by a non-hex character
               add_char(CH_BACKSLASH, 1'b0);
               case ($urandom_range(0, 2))
                  0: begin width = 2; add_char(CH_X, 1'b0); end
                  1: begin width = 4; add_char(CH_U_LOW, 1'b0); end
                  default: begin width = 8; add_char(CH_U_UP, 1'b0); end
               endcase
               case ($urandom_range(0, 3))
                  0: code = $urandom();
                  1: code = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
                  default: code = $urandom_range(0, 32'h0010_FFFF);
               endcase
               if (width < 8)
                  code = $urandom();
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, width - 1) : width;
               for (d = 0; d < count; d++) begin
                  nib = code[4 * (width - 1 - d) +: 4];
                  if (nib < 4'd10)
                     ch = CH_DIGIT_0 + nib;
                  else if ($urandom_range(0, 1) == 0)
                     ch = CH_HEX_A_UP + nib - 16'd10;
                  else
                     ch = CH_HEX_A_LO + nib - 16'd10;
                  add_char(ch, 1'b0);
               end
               if (count < width && $urandom_range(0, 1) == 0) begin
                  case ($urandom_range(0, 6))
                     0: ch = 16'h002F;
                     1: ch = 16'h003A;
                     2: ch = 16'h0040;
                     3: ch = 16'h0047;
                     4: ch = 16'h0060;
                     5: ch = 16'h0067;
                     default: ch = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
                  endcase
                  add_char(ch, 1'b0);
               end
            end
         end
         // sometimes leave a trailing backslash
         if ($urandom_range(0, 7) == 0)
            add_char(CH_BACKSLASH, 1'b0);
         text_plan[text_plan.size() - 1].last = 1'b1;
      end
      quiet_start = text_plan.size() * 85 / 100;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender: gaps in random bursts, none in the closing stretch
      for (d = 0; d < text_plan.size(); d++) begin
         if (d >= quiet_start) begin
            quiet_tail = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_char_in <= text_plan[d].ch;
         req_is_last <= text_plan[d].last;
         req_valid   <= 1'b1;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         items_sent++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (awaited_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && awaited_count == 0)
         $display("escape_sequence_to_utf16_decoder_top regression: pass");
      else
         $display("escape_sequence_to_utf16_decoder_top regression: fail");
      $finish;
   end

endmodule
